@@ src/spmsh_pkg.sv @@
// Shared types and constant tables for the seeded prime-mix string hash.
// Used by the front end, the chunk queue, the mix unit and the top level.
`timescale 1ns / 1ps

package spmsh_pkg;

	// Entries of the chunk queue between the packer and the mix unit
	localparam int unsigned FIFO_DEPTH = 4;

	// Register selects, decoded from paddr[3] (8-byte register slots)
	localparam logic REG_WIDE_MODE = 1'b0;
	localparam logic REG_HASH_SEED = 1'b1;

	// Every wide prime is 2^32 + offset, every narrow prime is 2^16 + offset,
	// so x * P reduces to a shift plus a multiply by a 9-bit offset.
	localparam logic [8:0] WIDE_OFS [16] = '{
		9'd15,  9'd61,  9'd75,  9'd81,  9'd91,  9'd93,  9'd163, 9'd181,
		9'd201, 9'd217, 9'd243, 9'd247, 9'd253, 9'd265, 9'd267, 9'd273
	};

	localparam logic [8:0] NARROW_OFS [16] = '{
		9'd1,   9'd3,   9'd7,   9'd15,  9'd21,  9'd27,  9'd43,  9'd45,
		9'd51,  9'd63,  9'd73,  9'd81,  9'd93,  9'd97,  9'd111, 9'd115
	};

	// One unit of work for the mix unit: a finished chunk or an empty message
	typedef struct packed {
		logic [31:0] chunk;
		logic [3:0]  idx;
		logic        wide;
		logic        first;
		logic        last;
		logic        empty;
	} chunk_op_t;

endpackage

@@ src/spmsh_front.sv @@
// Front end: accepts message bytes, packs them little-endian into chunks and
// issues chunk operations to the queue. Depends on spmsh_pkg.
`timescale 1ns / 1ps

module spmsh_front import spmsh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	input  logic        empty_message,
	input  logic        wide_mode,
	input  logic        q_full,
	output logic        q_push,
	output chunk_op_t   q_op
);

	logic        in_msg_q;
	logic        first_pend_q;
	logic [31:0] buf_q;
	logic [1:0]  fill_q;
	logic [3:0]  idx_q;

	logic        accept;
	logic        first_eff;
	logic        size_hit;
	logic        mix;
	logic [31:0] buf_new;
	logic [1:0]  fill_new;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		first_eff = !in_msg_q || first_pend_q;
		buf_new   = buf_q | ({24'd0, byte_value} << {fill_q, 3'b000});
		fill_new  = fill_q + 2'd1;
		if (wide_mode) begin
			size_hit = (fill_new == 2'd0);
		end else begin
			size_hit = (fill_new == 2'd0) || fill_new[1];
		end
		mix = size_hit || last_byte;
	end

	always_comb begin
		q_push      = accept && (empty_message || mix);
		q_op.chunk  = buf_new;
		q_op.idx    = idx_q;
		q_op.wide   = wide_mode;
		q_op.first  = first_eff;
		q_op.last   = last_byte;
		q_op.empty  = empty_message;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q     <= 1'b0;
			first_pend_q <= 1'b0;
			buf_q        <= '0;
			fill_q       <= '0;
			idx_q        <= '0;
		end else if (accept) begin
			if (empty_message || last_byte) begin
				// message done or dropped: back to idle
				in_msg_q     <= 1'b0;
				first_pend_q <= 1'b0;
				buf_q        <= '0;
				fill_q       <= '0;
				idx_q        <= '0;
			end else if (mix) begin
				in_msg_q     <= 1'b1;
				first_pend_q <= 1'b0;
				buf_q        <= '0;
				fill_q       <= '0;
				idx_q        <= idx_q + 4'd1;
			end else begin
				// hold the partial chunk; seed load still owed to the first mix
				in_msg_q     <= 1'b1;
				first_pend_q <= first_eff;
				buf_q        <= buf_new;
				fill_q       <= fill_new;
			end
		end
	end

endmodule

@@ src/spmsh_fifo.sv @@
// Short queue of chunk operations between the front end and the mix unit.
// Depends on spmsh_pkg for the entry type; DEPTH must be a power of two.
`timescale 1ns / 1ps

module spmsh_fifo import spmsh_pkg::*; #(
	parameter int unsigned DEPTH = FIFO_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  chunk_op_t push_op,
	output logic      full,
	input  logic      pop,
	output logic      head_valid,
	output chunk_op_t head_op
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	chunk_op_t       entry_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     count_q;

	logic do_push;
	logic do_pop;

	assign full       = (count_q == (AW+1)'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_op    = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (AW+1)'(1);
				2'b01:   count_q <= count_q - (AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ src/spmsh_back.sv @@
// Mix unit: applies acc*P[i] ^ chunk*P[i+8] for one chunk per cycle, holding a
// message's last op while the output hash register is unread. Depends on spmsh_pkg.
`timescale 1ns / 1ps

module spmsh_back import spmsh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        op_valid,
	input  chunk_op_t   op,
	output logic        op_pop,
	input  logic [63:0] hash_seed,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_hash
);

	logic [63:0] acc_q;
	logic        out_valid_q;
	logic [63:0] hash_q;

	logic [63:0] seed_sel;
	logic [63:0] base;
	logic [63:0] a;
	logic [63:0] c;
	logic [8:0]  ki;
	logic [8:0]  kj;
	logic [3:0]  jdx;
	logic [63:0] term_a;
	logic [63:0] term_c;
	logic [63:0] mixed_raw;
	logic [63:0] mixed;
	logic [63:0] result;
	logic        produce;

	always_comb begin
		seed_sel = op.wide ? hash_seed : {32'd0, hash_seed[31:0]};
		base     = op.first ? seed_sel : acc_q;
		jdx      = op.idx + 4'd8;
		if (op.wide) begin
			a      = base;
			c      = {32'd0, op.chunk};
			ki     = WIDE_OFS[op.idx];
			kj     = WIDE_OFS[jdx];
			term_a = (a << 32) + (a * {55'd0, ki});
			term_c = (c << 32) + (c * {55'd0, kj});
		end else begin
			a      = {32'd0, base[31:0]};
			c      = {48'd0, op.chunk[15:0]};
			ki     = NARROW_OFS[op.idx];
			kj     = NARROW_OFS[jdx];
			term_a = (a << 16) + (a * {55'd0, ki});
			term_c = (c << 16) + (c * {55'd0, kj});
		end
		mixed_raw = term_a ^ term_c;
		mixed     = op.wide ? mixed_raw : {32'd0, mixed_raw[31:0]};
		result    = op.empty ? seed_sel : mixed;
		produce   = op.empty || op.last;
	end

	// advance when the op yields no hash or the output slot frees up
	assign op_pop    = op_valid && (!produce || !out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_hash  = hash_q;

	always_ff @(posedge clk) begin
		if (op_pop) begin
			acc_q <= result;
		end
		if (op_pop && produce) begin
			hash_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op_pop && produce) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

@@ src/seeded_prime_mix_string_hash.sv @@
// Seeded prime-mix string hash: takes one message byte per cycle while the
// queue has room and returns one hash per message. The packer, the chunk
// queue and the mix unit run independently; the mix unit retires one chunk
// per cycle unless a finished hash waits at the output, so the block sustains
// one byte every cycle while the output keeps up. Registers are set over the
// APB port and must only change while no message is in flight. Depends on
// spmsh_pkg, spmsh_front, spmsh_fifo and spmsh_back.
`timescale 1ns / 1ps

module seeded_prime_mix_string_hash import spmsh_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// message byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_value
	input  logic        s_tlast,   // last_byte
	input  logic        s_tuser,   // [0] empty_message
	// hash stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [63:0] hash_value
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic        wide_q;
	logic [63:0] seed_q;
	logic        reg_sel;
	logic        reg_wr;

	logic        q_full;
	logic        q_push;
	chunk_op_t   q_in;
	logic        q_pop;
	logic        q_valid;
	chunk_op_t   q_head;

	// registers sit in 8-byte slots; low address bits are the byte offset
	assign reg_sel = paddr[3];
	assign reg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_comb begin
		case (reg_sel)
			REG_WIDE_MODE: prdata = {63'd0, wide_q};
			REG_HASH_SEED: prdata = seed_q;
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= 1'b1;
			seed_q <= '0;
		end else if (reg_wr) begin
			case (reg_sel)
				REG_WIDE_MODE: wide_q <= pwdata[0];
				REG_HASH_SEED: seed_q <= pwdata;
				default:       wide_q <= wide_q;
			endcase
		end
	end

	spmsh_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.byte_value    (s_tdata),
		.last_byte     (s_tlast),
		.empty_message (s_tuser),
		.wide_mode     (wide_q),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_op          (q_in)
	);

	spmsh_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_op    (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_op    (q_head)
	);

	spmsh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (q_valid),
		.op        (q_head),
		.op_pop    (q_pop),
		.hash_seed (seed_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_hash  (m_tdata)
	);

endmodule
